@@ sv/open_address_hash_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the open-address hash table.
// Simulation builds get concurrent assertions. Synthesis builds get empty
// bodies.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_TABLE_TOP_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Implication or plain property, checked on every rising edge out of reset.
`define OAHT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Condition that must never be true out of reset.
`define OAHT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define OAHT_ASSERT(label, clk, rstn, prop, msg)
`define OAHT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

@@ sv/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// oaht_pkg
// Types, codes and constants shared by the open-address hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

    // Default sizes.
    localparam int DEF_TABLE_SLOTS = 8;
    localparam int DEF_KEY_BYTES   = 8;
    localparam int MAX_KEY_BYTES   = 8;

    // Byte sum of up to eight bytes fits in 11 bits.
    localparam int SUM_W = 11;

    // floor(sum / 10) as (sum * 3277) >> 15, exact for sums up to 2040.
    localparam int RECIP_W     = 12;
    localparam int RECIP       = 3277;
    localparam int RECIP_SHIFT = 15;

    // Request codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    // Result codes.
    localparam logic [1:0] RES_OK   = 2'd0;
    localparam logic [1:0] RES_MISS = 2'd1;
    localparam logic [1:0] RES_FULL = 2'd2;

    // Slot states.
    localparam logic [1:0] SLOT_FREE = 2'd0;
    localparam logic [1:0] SLOT_USED = 2'd1;
    localparam logic [1:0] SLOT_TOMB = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key_bytes;
        logic [31:0] value_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot_index;
        logic [31:0] found_value;
        logic        rebuild_needed;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [63:0] key;
        logic [31:0] value;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    // floor(frac(0.7 * sum) * 11) as a function of sum mod 10.
    function automatic logic [3:0] home_lut(input logic [3:0] rem);
        logic [3:0] h;
        begin
            case (rem)
                4'd0:    h = 4'd0;
                4'd1:    h = 4'd7;
                4'd2:    h = 4'd4;
                4'd3:    h = 4'd1;
                4'd4:    h = 4'd8;
                4'd5:    h = 4'd5;
                4'd6:    h = 4'd2;
                4'd7:    h = 4'd9;
                4'd8:    h = 4'd6;
                4'd9:    h = 4'd3;
                default: h = 4'd0;
            endcase
            return h;
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/oaht_home_calc.sv @@
// ----------------------------------------------------------------------------
// oaht_home_calc
// Home slot from the key's byte sum: multiplication-method hash reduced
// modulo the table size.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_home_calc #(
    parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic [oaht_pkg::SUM_W-1:0]   sum_i,
    output logic      [$clog2(TABLE_SLOTS)-1:0] home_o
);

    localparam int SW     = $clog2(TABLE_SLOTS);
    localparam int CW     = SW + 2;
    localparam int PROD_W = oaht_pkg::SUM_W + oaht_pkg::RECIP_W;

    logic [PROD_W-1:0]         prod;
    logic [oaht_pkg::SUM_W-1:0] quot;
    logic [oaht_pkg::SUM_W-1:0] ten_quot;
    logic [oaht_pkg::SUM_W-1:0] rem_w;
    logic [3:0]                home_raw;
    logic [CW-1:0]             home_x;
    logic [CW-1:0]             home_red;

    // Remainder of the sum by ten through a reciprocal multiply.
    always_comb begin
        prod     = PROD_W'(sum_i) * PROD_W'(oaht_pkg::RECIP);
        quot     = oaht_pkg::SUM_W'(prod >> oaht_pkg::RECIP_SHIFT);
        ten_quot = (quot << 3) + (quot << 1);
        rem_w    = sum_i - ten_quot;
        home_raw = oaht_pkg::home_lut(rem_w[3:0]);
    end

    // The raw home is below 10, so at most two table sizes come off.
    always_comb begin
        home_x = CW'(home_raw);
        if (home_x >= CW'(2 * TABLE_SLOTS)) begin
            home_red = home_x - CW'(2 * TABLE_SLOTS);
        end else if (home_x >= CW'(TABLE_SLOTS)) begin
            home_red = home_x - CW'(TABLE_SLOTS);
        end else begin
            home_red = home_x;
        end
        home_o = home_red[SW-1:0];
    end

endmodule

`default_nettype wire

@@ sv/open_address_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// open_address_hash_table_top
// Fixed-size open-address hash table with quadratic probing. Serves
// insert, delete and find requests; slots live in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready with s_item (opcode, key bytes,
//   value word). Each request gives exactly one item on m_valid/m_ready
//   with m_item (status, slot index, found value, rebuild flag).
//   Keys end at the first zero byte; later bytes are ignored.
//   A request walks its probe chain one slot at a time: each probe is a
//   RAM read (ST_READ) and then a check (ST_CHECK), for up to TABLE_SLOTS
//   probes; an unknown opcode skips the probes. The next request is taken
//   only once the previous one has left ST_DONE.
//   After reset the block sweeps the slot RAM, marking every slot free;
//   s_ready stays low during the sweep.
//   The finished result sits in an output register. While the receiver
//   stalls, a new request is still accepted and processed; it waits in
//   its final state until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "open_address_hash_table_top_defines.svh"

module open_address_hash_table_top #(
    parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BYTES   = oaht_pkg::DEF_KEY_BYTES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire oaht_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output oaht_pkg::out_item_t      m_item
);

    localparam int SW     = $clog2(TABLE_SLOTS);
    localparam int TW     = $clog2(TABLE_SLOTS + 1);
    localparam int XW     = (SW > 3) ? SW : 3;
    localparam int THRESH = (TABLE_SLOTS * 2) / 5;

    oaht_pkg::state_t state_reg, state_next;

    // Request context.
    logic [1:0]                 op_reg;
    logic [63:0]                key_reg;
    logic [31:0]                val_reg;
    logic [oaht_pkg::SUM_W-1:0] sum_reg;

    // Probe walk.
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] inc_reg, inc_next;
    logic [SW-1:0] probe_cnt_reg;
    logic [SW-1:0] clr_cnt_reg;
    logic [SW-1:0] home_slot;

    // Table counters and result.
    logic [TW-1:0] tomb_cnt_reg;
    logic [1:0]    res_status_reg;
    logic [SW-1:0] res_slot_reg;
    logic [31:0]   res_value_reg;
    logic [XW-1:0] res_slot_x;

    logic                m_valid_reg;
    oaht_pkg::out_item_t m_item_reg;

    // Slot RAM.
    oaht_pkg::entry_t mem_ram [TABLE_SLOTS];
    oaht_pkg::entry_t rd_data_reg;
    oaht_pkg::entry_t mem_wdata;
    logic [SW-1:0]    rd_addr;
    logic [SW-1:0]    mem_waddr;
    logic             mem_we;

    // Key normalization.
    logic [63:0]                norm_key;
    logic [oaht_pkg::SUM_W-1:0] norm_sum;
    logic                       key_alive;

    // Probe decisions.
    logic op_known;
    logic is_free;
    logic is_hit;
    logic last_probe;
    logic ins_take;
    logic del_take;
    logic chk_finish;
    logic accept;
    logic out_load;

    logic [SW:0] slot_sum;
    logic [SW:0] inc_sum;

    // Home slot from the byte sum.
    oaht_home_calc #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_home (
        .sum_i (sum_reg),
        .home_o(home_slot)
    );

    // Keep bytes before the first zero, up to KEY_BYTES, and sum them.
    always_comb begin
        key_alive = 1'b1;
        norm_key  = '0;
        norm_sum  = '0;
        for (int b = 0; b < oaht_pkg::MAX_KEY_BYTES; b++) begin
            if (b >= KEY_BYTES || s_item.key_bytes[8*b +: 8] == 8'd0) begin
                key_alive = 1'b0;
            end
            if (key_alive) begin
                norm_key[8*b +: 8] = s_item.key_bytes[8*b +: 8];
                norm_sum = norm_sum + oaht_pkg::SUM_W'(s_item.key_bytes[8*b +: 8]);
            end
        end
    end

    // Decisions on the slot just read.
    always_comb begin
        op_known   = (op_reg == oaht_pkg::OP_INSERT) || (op_reg == oaht_pkg::OP_DELETE)
                     || (op_reg == oaht_pkg::OP_FIND);
        is_free    = (rd_data_reg.state == oaht_pkg::SLOT_FREE);
        is_hit     = (rd_data_reg.state == oaht_pkg::SLOT_USED) && (rd_data_reg.key == key_reg);
        last_probe = (probe_cnt_reg == SW'(TABLE_SLOTS - 1));
        ins_take   = (op_reg == oaht_pkg::OP_INSERT) && is_free;
        del_take   = (op_reg == oaht_pkg::OP_DELETE) && is_hit;
        if (op_reg == oaht_pkg::OP_INSERT) begin
            chk_finish = is_free || last_probe;
        end else begin
            chk_finish = is_hit || is_free || last_probe;
        end
    end

    // Next probe: slot advances by 2i+1 and the step grows by two, both mod size.
    always_comb begin
        slot_sum = {1'b0, slot_reg} + {1'b0, inc_reg};
        inc_sum  = {1'b0, inc_reg} + (SW + 1)'(2);
        if (slot_sum >= (SW + 1)'(TABLE_SLOTS)) begin
            slot_next = SW'(slot_sum - (SW + 1)'(TABLE_SLOTS));
        end else begin
            slot_next = slot_sum[SW-1:0];
        end
        if (inc_sum >= (SW + 1)'(TABLE_SLOTS)) begin
            inc_next = SW'(inc_sum - (SW + 1)'(TABLE_SLOTS));
        end else begin
            inc_next = inc_sum[SW-1:0];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            oaht_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == SW'(TABLE_SLOTS - 1)) begin
                    state_next = oaht_pkg::ST_IDLE;
                end
            end
            oaht_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = oaht_pkg::ST_HASH;
                end
            end
            oaht_pkg::ST_HASH: begin
                state_next = op_known ? oaht_pkg::ST_READ : oaht_pkg::ST_DONE;
            end
            oaht_pkg::ST_READ: begin
                state_next = oaht_pkg::ST_CHECK;
            end
            oaht_pkg::ST_CHECK: begin
                state_next = chk_finish ? oaht_pkg::ST_DONE : oaht_pkg::ST_READ;
            end
            oaht_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = oaht_pkg::ST_IDLE;
                end
            end
            default: state_next = oaht_pkg::ST_CLEAR;
        endcase
    end

    // State machine outputs: handshake, RAM port controls, result load.
    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        rd_addr   = slot_reg;
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = '{state: oaht_pkg::SLOT_USED, key: key_reg, value: val_reg};
        unique case (state_reg)
            oaht_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '{state: oaht_pkg::SLOT_FREE, key: 64'd0, value: 32'd0};
            end
            oaht_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            oaht_pkg::ST_CHECK: begin
                mem_we = ins_take || del_take;
                if (del_take) begin
                    mem_wdata = '{state: oaht_pkg::SLOT_TOMB, key: rd_data_reg.key,
                                  value: rd_data_reg.value};
                end
            end
            oaht_pkg::ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // Slot RAM, one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ram[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_ram[rd_addr];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= oaht_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            tomb_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == oaht_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SW'(1);
            end
            if (state_reg == oaht_pkg::ST_CHECK && del_take) begin
                tomb_cnt_reg <= tomb_cnt_reg + TW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request context and probe walk. An insert that meets its own key
    // keeps probing, so only a free slot ends it with success.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= s_item.opcode;
            key_reg        <= norm_key;
            val_reg        <= s_item.value_word;
            sum_reg        <= norm_sum;
            res_status_reg <= oaht_pkg::RES_MISS;
            res_slot_reg   <= '0;
            res_value_reg  <= '0;
        end
        if (state_reg == oaht_pkg::ST_HASH) begin
            slot_reg      <= home_slot;
            inc_reg       <= SW'(1);
            probe_cnt_reg <= '0;
        end
        if (state_reg == oaht_pkg::ST_CHECK) begin
            if (ins_take || (is_hit && op_reg != oaht_pkg::OP_INSERT)) begin
                res_status_reg <= oaht_pkg::RES_OK;
                res_slot_reg   <= slot_reg;
                if (op_reg == oaht_pkg::OP_FIND) begin
                    res_value_reg <= rd_data_reg.value;
                end
            end else if (op_reg == oaht_pkg::OP_INSERT && last_probe) begin
                res_status_reg <= oaht_pkg::RES_FULL;
            end
            slot_reg      <= slot_next;
            inc_reg       <= inc_next;
            probe_cnt_reg <= probe_cnt_reg + SW'(1);
        end
    end

    // Output register.
    assign res_slot_x = XW'(res_slot_reg);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg.status         <= res_status_reg;
            m_item_reg.slot_index     <= res_slot_x[2:0];
            m_item_reg.found_value    <= res_value_reg;
            m_item_reg.rebuild_needed <= (tomb_cnt_reg >= TW'(THRESH));
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Assertions.
    `OAHT_ASSERT(a_slot_in_range, aclk, aresetn, (state_reg == oaht_pkg::ST_READ || state_reg == oaht_pkg::ST_CHECK) |-> ({1'b0, slot_reg} < (SW + 1)'(TABLE_SLOTS)), "probe slot outside table")
    `OAHT_NEVER(a_tomb_bound, aclk, aresetn, tomb_cnt_reg > TW'(TABLE_SLOTS), "tombstone count exceeds table size")
    `OAHT_ASSERT(a_tomb_step, aclk, aresetn, (state_reg == oaht_pkg::ST_CHECK && del_take) |=> (tomb_cnt_reg == $past(tomb_cnt_reg) + TW'(1)), "delete hit did not add a tombstone")
    `OAHT_ASSERT(a_load_free, aclk, aresetn, out_load |-> (!m_valid_reg || m_ready), "result overwrote an unread item")

endmodule

`default_nettype wire

@@ dv/oaht_table_checker.sv @@
// ----------------------------------------------------------------------------
// oaht_table_checker
// Watches both channels of the open-address hash table. It keeps a shadow
// copy of the slot array and counters, predicts the answer to every
// accepted request, and compares each answered item field by field with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module oaht_table_checker #(
    parameter int TABLE_SLOTS = oaht_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BYTES   = oaht_pkg::DEF_KEY_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  oaht_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  oaht_pkg::out_item_t m_item,
    output int unsigned         fail_count,
    output int unsigned         answers_owed
);

    import oaht_pkg::*;

    // Shadow slot array and occupancy counters.
    logic [63:0] shadow_key   [TABLE_SLOTS];
    logic [31:0] shadow_value [TABLE_SLOTS];
    logic [1:0]  shadow_state [TABLE_SLOTS];
    int unsigned live_entries;
    int unsigned dead_entries;
    int unsigned mismatches;

    // Predicted answers, oldest first.
    out_item_t pending_answers[$];

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch in %s: got %0h, predicted %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Keep the bytes before the first zero byte and add them up.
    function automatic logic [63:0] trim_key(input logic [63:0] raw,
                                             output int unsigned sum);
        logic [63:0] kept;
        logic [7:0]  b;
        bit          ended;
        kept  = '0;
        sum   = 0;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            b = raw[8*i +: 8];
            if (b == 8'd0)
                ended = 1'b1;
            if (!ended) begin
                kept[8*i +: 8] = b;
                sum += b;
            end
        end
        return kept;
    endfunction

    // Home slot is floor(frac(0.7 * sum) * 11), done in integers; probe
    // step adds the square of the step number.
    function automatic int unsigned probe_slot(input int unsigned sum,
                                               input int unsigned step);
        int unsigned home;
        home = ((7 * sum) % 10) * 11 / 10;
        return (home + step * step) % TABLE_SLOTS;
    endfunction

    // Apply one request to the shadow table and return its answer.
    function automatic out_item_t predict_table_op(input in_item_t req);
        out_item_t   ans;
        logic [63:0] key;
        int unsigned sum;
        int unsigned s;
        bit          done;
        key             = trim_key(req.key_bytes, sum);
        ans.status      = RES_MISS;
        ans.slot_index  = '0;
        ans.found_value = '0;
        done            = 1'b0;
        case (req.opcode)
            OP_INSERT: begin
                // Take the first free slot; tombstones are never reused.
                ans.status = RES_FULL;
                for (int i = 0; i < TABLE_SLOTS && !done; i++) begin
                    s = probe_slot(sum, i);
                    if (shadow_state[s] == SLOT_FREE) begin
                        shadow_key[s]   = key;
                        shadow_value[s] = req.value_word;
                        shadow_state[s] = SLOT_USED;
                        live_entries++;
                        ans.status     = RES_OK;
                        ans.slot_index = 3'(s);
                        done           = 1'b1;
                    end
                end
            end
            OP_DELETE, OP_FIND: begin
                // Skip tombstones, stop at a free slot or a matching entry.
                for (int i = 0; i < TABLE_SLOTS && !done; i++) begin
                    s = probe_slot(sum, i);
                    if (shadow_state[s] == SLOT_USED && shadow_key[s] == key) begin
                        ans.status     = RES_OK;
                        ans.slot_index = 3'(s);
                        if (req.opcode == OP_DELETE) begin
                            shadow_state[s] = SLOT_TOMB;
                            if (live_entries > 0)
                                live_entries--;
                            dead_entries++;
                        end else begin
                            ans.found_value = shadow_value[s];
                        end
                        done = 1'b1;
                    end else if (shadow_state[s] == SLOT_FREE) begin
                        done = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        ans.rebuild_needed = (dead_entries >= (TABLE_SLOTS * 2) / 5);
        return ans;
    endfunction

    // Compare answered items first, then record predictions for new requests.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                shadow_key[i]   = '0;
                shadow_value[i] = '0;
                shadow_state[i] = SLOT_FREE;
            end
            live_entries = 0;
            dead_entries = 0;
            mismatches   = 0;
            pending_answers.delete();
            fail_count   <= 0;
            answers_owed <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("item with no request waiting", 64'(m_item), 64'd0);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_item.status !== want.status)
                        report_mismatch("status", m_item.status, want.status);
                    if (m_item.slot_index !== want.slot_index)
                        report_mismatch("slot_index", m_item.slot_index, want.slot_index);
                    if (m_item.found_value !== want.found_value)
                        report_mismatch("found_value", m_item.found_value, want.found_value);
                    if (m_item.rebuild_needed !== want.rebuild_needed)
                        report_mismatch("rebuild_needed", m_item.rebuild_needed,
                                        want.rebuild_needed);
                end
            end
            if (s_valid && s_ready)
                pending_answers.push_back(predict_table_op(s_item));
            fail_count   <= mismatches;
            answers_owed <= pending_answers.size();
        end
    end

endmodule

@@ dv/tb_open_address_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// tb_open_address_hash_table_top
// Drives insert, delete and find requests into the hash table: a directed
// opening that walks through empty keys, duplicates, tombstones, a full
// probe chain and the rebuild flag, then random requests that mostly reuse
// keys already inserted. Both sides pause at random, and the receiver holds
// off twice for a long stretch. A separate checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_open_address_hash_table_top;

    import oaht_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 300;

    // Directed keys, first byte lowest.
    localparam logic [63:0] KEY_A       = 64'h0000_0000_0000_0041;
    localparam logic [63:0] KEY_B       = 64'h0000_0000_0000_0042;
    localparam logic [63:0] KEY_K       = 64'h0000_0000_0000_004B;
    localparam logic [63:0] KEY_AB      = 64'hFFEE_DD00_0000_4241;
    localparam logic [63:0] KEY_AB_ALT  = 64'h1234_5600_0000_4241;
    localparam logic [63:0] KEY_EMPTY   = 64'h0000_0000_0000_0000;
    localparam logic [63:0] KEY_EMPTY_T = 64'hA5A5_A5A5_A5A5_A500;
    localparam logic [63:0] KEY_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int unsigned fail_count;
    int unsigned answers_owed;
    int unsigned sent_count;
    int unsigned taken_count;
    int unsigned rx_hold;
    int unsigned idle_cycles = 0;
    logic [63:0] key_pool[$];

    always #5 aclk = ~aclk;

    open_address_hash_table_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    oaht_table_checker table_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .fail_count   (fail_count),
        .answers_owed (answers_owed)
    );

    // Random key: 0 to 8 nonzero bytes, a zero byte if room is left, then random leftovers.
    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        int unsigned len;
        k   = {$urandom, $urandom};
        len = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++) begin
            if (i < len) begin
                if (k[8*i +: 8] == 8'd0)
                    k[8*i +: 8] = 8'($urandom_range(1, 255));
            end else if (i == len) begin
                k[8*i +: 8] = 8'h00;
            end
        end
        return k;
    endfunction

    // Same key, new random bytes after the terminating zero byte.
    function automatic logic [63:0] vary_tail(input logic [63:0] raw);
        logic [63:0] k;
        bit          ended;
        k     = raw;
        ended = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (ended)
                k[8*i +: 8] = 8'($urandom);
            else if (raw[8*i +: 8] == 8'd0)
                ended = 1'b1;
        end
        return k;
    endfunction

    // Offer one request after a random pause and wait until it is taken.
    task automatic send_request(input logic [1:0] op, input logic [63:0] key,
                                input logic [31:0] value);
        int unsigned gap;
        in_item_t    req;
        req.opcode     = op;
        req.key_bytes  = key;
        req.value_word = value;
        gap = (((sent_count / 50) % 4) == 1) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_INSERT)
            key_pool.push_back(key);
        sent_count++;
    endtask

    // Mostly keys seen before, so finds and deletes hit live entries.
    task automatic send_random_request();
        int unsigned pick;
        logic [1:0]  op;
        logic [63:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            op = OP_INSERT;
        else if (pick < 45)
            op = OP_DELETE;
        else if (pick < 95)
            op = OP_FIND;
        else
            op = OP_UNUSED;
        if (key_pool.size() != 0 && $urandom_range(0, 9) < 7)
            key = vary_tail(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        else
            key = fresh_key();
        send_request(op, key, $urandom);
    endtask

    // Receiver: random hold before each item, bursts with no hold, and two
    // long hold-offs that back the block up into its input.
    initial begin
        m_ready     = 1'b0;
        taken_count = 0;
        rx_hold     = $urandom_range(0, 19);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                taken_count++;
                if (taken_count == 60 || taken_count == 300)
                    rx_hold = LONG_HOLD;
                else if (((taken_count / 50) % 4) == 3)
                    rx_hold = 0;
                else
                    rx_hold = $urandom_range(0, 19);
                if (rx_hold != 0)
                    m_ready <= 1'b0;
            end else if (!m_ready) begin
                if (rx_hold <= 1)
                    m_ready <= 1'b1;
                else
                    rx_hold--;
            end
        end
    end

    // Watchdog: too long with no item moving on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and verdict.
    initial begin
        s_valid    = 1'b0;
        s_item     = '0;
        aresetn    = 1'b0;
        sent_count = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Lookups on an empty table.
        send_request(OP_FIND,   KEY_A, 32'h0000_0000);
        send_request(OP_DELETE, KEY_A, 32'hFFFF_FFFF);
        // Fill: plain key, empty key, key with bytes past its end, longest key.
        send_request(OP_INSERT, KEY_A,     32'hFFFF_FFFF);
        send_request(OP_INSERT, KEY_EMPTY, 32'h0000_0000);
        send_request(OP_INSERT, KEY_AB,    32'h1234_5678);
        send_request(OP_INSERT, KEY_ONES,  32'h8000_0001);
        // A duplicate is stored as a second copy.
        send_request(OP_INSERT, KEY_A,     32'h0000_0002);
        send_request(OP_FIND,   KEY_A,       32'h0);
        send_request(OP_FIND,   KEY_AB_ALT,  32'h0);
        send_request(OP_FIND,   KEY_EMPTY_T, 32'h0);
        send_request(OP_UNUSED, KEY_ONES,    32'hFFFF_FFFF);
        // Deletes leave tombstones that finds step over.
        send_request(OP_DELETE, KEY_A, 32'h0);
        send_request(OP_FIND,   KEY_A, 32'h0);
        send_request(OP_DELETE, KEY_A, 32'h0);
        send_request(OP_FIND,   KEY_A, 32'h0);
        // Third tombstone raises the rebuild flag.
        send_request(OP_DELETE, KEY_ONES, 32'h0);
        // Same home as the deleted KEY_A: every reachable slot is taken.
        send_request(OP_INSERT, KEY_K, 32'hDEAD_BEEF);
        send_request(OP_FIND,   KEY_K, 32'h0);
        send_request(OP_INSERT, KEY_B, 32'h5A5A_5A5A);
        send_request(OP_FIND,   KEY_B, 32'h0);
        send_request(OP_DELETE, KEY_EMPTY_T, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_random_request();
        s_valid <= 1'b0;

        // Let the last prediction register, then wait for every answer.
        @(posedge aclk);
        while (answers_owed != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ open_address_hash_table_top.f @@
+incdir+sv
sv/oaht_pkg.sv
sv/oaht_home_calc.sv
sv/open_address_hash_table_top.sv
dv/oaht_table_checker.sv
dv/tb_open_address_hash_table_top.sv
